// ===== rtl/kwl_pkg.sv =====
// Shared types, character codes, token kinds and the keyword table of the lexer.
`timescale 1ns / 1ps
package kwl_pkg;

	localparam int KWL_KEYWORD_MAX_LEN = 10;
	localparam int KWL_COUNTER_BITS    = 16;

	localparam int KW_COUNT    = 26;
	localparam int KW_TEXT_LEN = 10;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUMBER,
		MODE_SLASH,
		MODE_COMMENT
	} scan_mode_t;

	typedef enum logic [5:0] {
		KIND_EOF    = 6'd0,
		KIND_NUMBER = 6'd27,
		KIND_IDENT  = 6'd28,
		KIND_LBRACE = 6'd29,
		KIND_RBRACE = 6'd30,
		KIND_COLON  = 6'd31,
		KIND_SEMI   = 6'd32,
		KIND_DOT    = 6'd33,
		KIND_ERROR  = 6'd34
	} token_kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef logic [8*KW_TEXT_LEN-1:0] kw_text_t;

	// Literals are right-justified: the last character sits in the low byte.
	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		"ecu", "signal", "can", "flexray", "process", "input", "output",
		"filter", "diagnostic", "service", "session", "security", "request",
		"response", "routine", "did", "pattern", "match", "timeout", "flow",
		"frame", "id", "dlc", "extended", "periodic", "trigger"
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd6, 4'd3, 4'd7, 4'd7, 4'd5, 4'd6, 4'd6, 4'd10, 4'd7,
		4'd7, 4'd8, 4'd7, 4'd8, 4'd7, 4'd3, 4'd7, 4'd5, 4'd7, 4'd4,
		4'd5, 4'd2, 4'd3, 4'd8, 4'd8, 4'd7
	};

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic        last_of_run;
	} tok_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t       tok_a;
		tok_t       tok_b;
	} scan_out_t;

	function automatic logic ident_start(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER});
	endfunction

	function automatic logic dec_digit(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_COLON:  k = KIND_COLON;
			CH_SEMI:   k = KIND_SEMI;
			CH_DOT:    k = KIND_DOT;
			default:   k = KIND_ERROR;
		endcase
		return k;
	endfunction

	// First table entry wins; a length of zero never matches.
	function automatic logic [5:0] kw_lookup(input logic [7:0] pfx [KW_TEXT_LEN],
	                                        input logic [3:0] len);
		logic [5:0] kind;
		logic       hit;
		kind = KIND_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (len == KW_LEN[i]);
			for (int j = 0; j < KW_TEXT_LEN; j++) begin
				if (j < int'(KW_LEN[i])) begin
					hit = hit && (pfx[j] == KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8]);
				end
			end
			if (hit) begin
				kind = 6'(i + 1);
			end
		end
		return kind;
	endfunction

endpackage

// ===== rtl/kwl_if.sv =====
// Valid/ready channels for text bytes in and tokens out.
`timescale 1ns / 1ps
interface kwl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

interface kwl_tok_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic        last_of_run;

	modport source(output valid, output token_kind, output start_offset,
	               output token_length, output start_line, output start_column,
	               output last_of_run, input ready);
	modport sink(input valid, input token_kind, input start_offset,
	             input token_length, input start_line, input start_column,
	             input last_of_run, output ready);
endinterface

// ===== rtl/kwl_scan.sv =====
// Scanner state, position counters and the per-byte token decision.
`timescale 1ns / 1ps
module kwl_scan import kwl_pkg::*; #(
	parameter int KEYWORD_MAX_LEN = KWL_KEYWORD_MAX_LEN,
	parameter int COUNTER_BITS    = KWL_COUNTER_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] text_byte,
	output scan_out_t  beats
);

	localparam int CB   = COUNTER_BITS;
	localparam int IDXW = $clog2(KEYWORD_MAX_LEN);

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] fit16(input logic [CB-1:0] v);
		logic [CB+15:0] ext;
		ext = {16'd0, v};
		return ext[15:0];
	endfunction

	scan_mode_t      mode_q, mode_d;
	logic [7:0]      prefix_q [KEYWORD_MAX_LEN];
	logic [7:0]      kw_pfx [KW_TEXT_LEN];
	logic [CB-1:0]   plen_q, plen_d, poff_q, poff_d, pline_q, pline_d, pcol_q, pcol_d;
	logic [CB-1:0]   coff_q, coff_d, cline_q, cline_d, ccol_q, ccol_d;
	logic            wr_en;
	logic [IDXW-1:0] wr_idx;

	logic is_nul, is_ws, is_lf, is_sl, is_al, is_dg, is_dot;
	logic held, p1_emit, p2_emit;
	logic [3:0] kw_len;
	tok_t pend_tok, p2_tok;

	assign is_nul = (text_byte == CH_NUL);
	assign is_ws  = (text_byte inside {CH_SPACE, CH_TAB, CH_CR});
	assign is_lf  = (text_byte == CH_LF);
	assign is_sl  = (text_byte == CH_SLASH);
	assign is_al  = ident_start(text_byte);
	assign is_dg  = dec_digit(text_byte);
	assign is_dot = (text_byte == CH_DOT);

	// The byte is swallowed by the token or comment under way.
	assign held = (mode_q == MODE_WORD && (is_al || is_dg))
	           || (mode_q == MODE_NUMBER && (is_dg || is_dot))
	           || (mode_q == MODE_SLASH && is_sl)
	           || (mode_q == MODE_COMMENT && !is_nul && !is_lf);

	assign p1_emit = (mode_q == MODE_WORD && !(is_al || is_dg))
	              || (mode_q == MODE_NUMBER && !(is_dg || is_dot))
	              || (mode_q == MODE_SLASH && !is_sl);

	assign p2_emit = !held && !(is_ws || is_lf || is_sl || is_al || is_dg);

	always_comb begin
		for (int j = 0; j < KW_TEXT_LEN; j++) begin
			kw_pfx[j] = prefix_q[j];
		end
	end

	assign kw_len = (plen_q <= CB'(KW_TEXT_LEN)) ? plen_q[3:0] : 4'd0;

	// Next scan mode
	always_comb begin
		if (held) begin
			mode_d = (mode_q == MODE_SLASH) ? MODE_COMMENT : mode_q;
		end else if (is_sl) begin
			mode_d = MODE_SLASH;
		end else if (is_al) begin
			mode_d = MODE_WORD;
		end else if (is_dg) begin
			mode_d = MODE_NUMBER;
		end else begin
			mode_d = MODE_IDLE;
		end
	end

	// Counters and prefix write
	always_comb begin
		plen_d  = plen_q;
		poff_d  = poff_q;
		pline_d = pline_q;
		pcol_d  = pcol_q;
		coff_d  = coff_q;
		cline_d = cline_q;
		ccol_d  = ccol_q;
		wr_en   = 1'b0;
		wr_idx  = '0;
		if (held) begin
			if (mode_q == MODE_WORD || mode_q == MODE_NUMBER) begin
				plen_d = sat_inc(plen_q);
			end
			if (mode_q == MODE_WORD && plen_d <= CB'(KEYWORD_MAX_LEN)) begin
				wr_en  = 1'b1;
				wr_idx = IDXW'(plen_d - 1'b1);
			end
			coff_d = sat_inc(coff_q);
			ccol_d = sat_inc(ccol_q);
		end else if (is_nul) begin
			plen_d  = '0;
			poff_d  = '0;
			pline_d = CB'(1);
			pcol_d  = CB'(1);
			coff_d  = '0;
			cline_d = CB'(1);
			ccol_d  = CB'(1);
		end else if (is_lf) begin
			coff_d  = sat_inc(coff_q);
			cline_d = sat_inc(cline_q);
			ccol_d  = CB'(1);
		end else begin
			if (is_sl || is_al || is_dg) begin
				plen_d  = CB'(1);
				poff_d  = coff_q;
				pline_d = cline_q;
				pcol_d  = ccol_q;
			end
			wr_en  = is_al;
			coff_d = sat_inc(coff_q);
			ccol_d = sat_inc(ccol_q);
		end
	end

	// Result beats
	always_comb begin
		pend_tok.start_offset = fit16(poff_q);
		pend_tok.start_line   = fit16(pline_q);
		pend_tok.start_column = fit16(pcol_q);
		pend_tok.token_length = (mode_q == MODE_SLASH) ? 16'd1 : fit16(plen_q);
		pend_tok.last_of_run  = !p2_emit;
		case (mode_q)
			MODE_WORD:   pend_tok.token_kind = kw_lookup(kw_pfx, kw_len);
			MODE_NUMBER: pend_tok.token_kind = KIND_NUMBER;
			default:     pend_tok.token_kind = KIND_ERROR;
		endcase

		p2_tok.token_kind   = is_nul ? 6'(KIND_EOF) : punct_kind(text_byte);
		p2_tok.start_offset = fit16(coff_q);
		p2_tok.start_line   = fit16(cline_q);
		p2_tok.start_column = fit16(ccol_q);
		p2_tok.token_length = is_nul ? 16'd0 : 16'd1;
		p2_tok.last_of_run  = 1'b1;

		beats.count = {1'b0, p1_emit} + {1'b0, p2_emit};
		beats.tok_a = p1_emit ? pend_tok : p2_tok;
		beats.tok_b = p2_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			plen_q  <= '0;
			poff_q  <= '0;
			pline_q <= CB'(1);
			pcol_q  <= CB'(1);
			coff_q  <= '0;
			cline_q <= CB'(1);
			ccol_q  <= CB'(1);
		end else if (fire) begin
			mode_q  <= mode_d;
			plen_q  <= plen_d;
			poff_q  <= poff_d;
			pline_q <= pline_d;
			pcol_q  <= pcol_d;
			coff_q  <= coff_d;
			cline_q <= cline_d;
			ccol_q  <= ccol_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			prefix_q[wr_idx] <= text_byte;
		end
	end

endmodule

// ===== rtl/kwl_obuf.sv =====
// Two-beat output buffer that parts the scanner from the token sink.
`timescale 1ns / 1ps
module kwl_obuf import kwl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  scan_out_t   beats,
	output logic [1:0]  free_slots,
	kwl_tok_if.source   tokens
);

	tok_t       slot_q [2];
	tok_t       slot_d [2];
	tok_t       rem_head;
	logic [1:0] count_q, count_d, rem, n_push;
	logic       pop;

	assign pop        = tokens.valid && tokens.ready;
	assign free_slots = 2'd2 - count_q;

	always_comb begin
		rem      = count_q - {1'b0, pop};
		n_push   = push ? beats.count : 2'd0;
		rem_head = pop ? slot_q[1] : slot_q[0];
		count_d  = rem + n_push;
		case (rem)
			2'd0: begin
				slot_d[0] = beats.tok_a;
				slot_d[1] = beats.tok_b;
			end
			2'd1: begin
				slot_d[0] = rem_head;
				slot_d[1] = beats.tok_a;
			end
			default: begin
				slot_d[0] = slot_q[0];
				slot_d[1] = slot_q[1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_d[0];
		slot_q[1] <= slot_d[1];
	end

	assign tokens.valid        = (count_q != 2'd0);
	assign tokens.token_kind   = slot_q[0].token_kind;
	assign tokens.start_offset = slot_q[0].start_offset;
	assign tokens.token_length = slot_q[0].token_length;
	assign tokens.start_line   = slot_q[0].start_line;
	assign tokens.start_column = slot_q[0].start_column;
	assign tokens.last_of_run  = slot_q[0].last_of_run;

endmodule

// ===== rtl/keyword_token_lexer.sv =====
// Top level of the keyword lexer: input register, scanner and output buffer.
// The lexer takes one text byte per cycle while the output buffer has room and
// emits tokens (keyword, identifier, number, punctuation, error, EOF) with
// saturating offset, length, line and column. A token leaves when the byte after
// it arrives, once that byte has passed the byte register and the output buffer;
// a zero byte flushes the pending token, emits EOF and restarts the counters for
// the next text. Sustained rate is one byte per cycle while the sink is ready and
// no byte yields two beats. A byte that both ends a token and is a token itself
// (or is the end of text) yields two beats: it waits in the byte register until
// the two-entry output buffer is empty, and a byte behind it that yields a beat
// waits until one of the pair has left. Output stalls back up into the input
// only through that buffer's fill level. No clearing pass follows reset.
`timescale 1ns / 1ps
module keyword_token_lexer import kwl_pkg::*; #(
	parameter int KEYWORD_MAX_LEN = KWL_KEYWORD_MAX_LEN,
	parameter int COUNTER_BITS    = KWL_COUNTER_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	kwl_byte_if.sink   text,
	kwl_tok_if.source  tokens
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic [1:0] free_slots;
	scan_out_t  beats;

	// Consume the registered byte once its beats fit in the buffer.
	assign fire       = valid_s1 && (beats.count <= free_slots);
	assign text.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
		end
	end

	kwl_scan #(
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
		.COUNTER_BITS   (COUNTER_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.text_byte(byte_s1),
		.beats    (beats)
	);

	kwl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.beats     (beats),
		.free_slots(free_slots),
		.tokens    (tokens)
	);

`ifndef SYNTH
	a_hold_stalled_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(byte_s1))
		else $error("stalled byte register changed");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.ready && !tokens.last_of_run |=> tokens.valid)
		else $error("second beat of a run missing");

	a_pair_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beats.count == 2'd2 |=> tokens.valid && !tokens.last_of_run)
		else $error("two-beat run not at buffer head");
`endif

endmodule

// ===== tb/tb_keyword_token_lexer.sv =====
// Self-checking testbench of the keyword lexer against a token predictor.
`timescale 1ns / 1ps
module tb_keyword_token_lexer;
	import kwl_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_BYTES  = 90;

	logic clk = 1'b0;
	logic arst_n;

	kwl_byte_if byte_ch();
	kwl_tok_if  tok_ch();

	keyword_token_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (byte_ch),
		.tokens (tok_ch)
	);

	always #5 clk = ~clk;

	string kw_words [26] = '{
		"ecu", "signal", "can", "flexray", "process", "input", "output",
		"filter", "diagnostic", "service", "session", "security", "request",
		"response", "routine", "did", "pattern", "match", "timeout", "flow",
		"frame", "id", "dlc", "extended", "periodic", "trigger"
	};
	string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	logic [7:0]  text_queue [$];
	tok_t        tokens_due [$];
	int          pushed;
	int          send_idle;
	int          recv_idle;
	int          err_count    = 0;
	int unsigned stall_cycles = 0;

	// Lexer state as the predictor sees it
	scan_mode_t  lex_mode;
	logic [7:0]  word_buf [KWL_KEYWORD_MAX_LEN];
	logic [15:0] tok_len, tok_off, tok_line, tok_col;
	logic [15:0] cur_off, cur_line, cur_col;

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic letter_like(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
	endfunction

	function automatic logic digit_like(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void clear_lex();
		lex_mode = MODE_IDLE;
		foreach (word_buf[i]) word_buf[i] = 8'h00;
		tok_len  = 16'd0;
		tok_off  = 16'd0;
		tok_line = 16'd1;
		tok_col  = 16'd1;
		cur_off  = 16'd0;
		cur_line = 16'd1;
		cur_col  = 16'd1;
	endfunction

	function automatic void advance_cursor();
		cur_off = bump(cur_off);
		cur_col = bump(cur_col);
	endfunction

	function automatic void mark_token_start();
		tok_off  = cur_off;
		tok_line = cur_line;
		tok_col  = cur_col;
		tok_len  = 16'd1;
	endfunction

	function automatic tok_t make_tok(input logic [5:0] kind, input logic [15:0] off,
	                                  input logic [15:0] len, input logic [15:0] line,
	                                  input logic [15:0] col);
		tok_t t;
		t.token_kind   = kind;
		t.start_offset = off;
		t.token_length = len;
		t.start_line   = line;
		t.start_column = col;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	// First keyword in table order wins; words past the kept prefix are identifiers.
	function automatic logic [5:0] word_class();
		logic hit;
		if (tok_len > 16'(KWL_KEYWORD_MAX_LEN)) return KIND_IDENT;
		for (int i = 0; i < 26; i++) begin
			if (int'(tok_len) == kw_words[i].len()) begin
				hit = 1'b1;
				for (int j = 0; j < kw_words[i].len(); j++)
					if (word_buf[j] != 8'(kw_words[i][j])) hit = 1'b0;
				if (hit) return 6'(i + 1);
			end
		end
		return KIND_IDENT;
	endfunction

	function automatic void lex_byte(input logic [7:0] c);
		tok_t       run [$];
		logic       held;
		logic [5:0] k;
		held = 1'b0;
		case (lex_mode)
			MODE_WORD: begin
				if (letter_like(c) || digit_like(c)) begin
					tok_len = bump(tok_len);
					if (tok_len <= 16'(KWL_KEYWORD_MAX_LEN)) word_buf[tok_len - 16'd1] = c;
					advance_cursor();
					held = 1'b1;
				end else begin
					run.push_back(make_tok(word_class(), tok_off, tok_len, tok_line, tok_col));
					lex_mode = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (digit_like(c) || c == CH_DOT) begin
					tok_len = bump(tok_len);
					advance_cursor();
					held = 1'b1;
				end else begin
					run.push_back(make_tok(KIND_NUMBER, tok_off, tok_len, tok_line, tok_col));
					lex_mode = MODE_IDLE;
				end
			end
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					lex_mode = MODE_COMMENT;
					advance_cursor();
					held = 1'b1;
				end else begin
					run.push_back(make_tok(KIND_ERROR, tok_off, 16'd1, tok_line, tok_col));
					lex_mode = MODE_IDLE;
				end
			end
			MODE_COMMENT: begin
				if (c != CH_NUL && c != CH_LF) begin
					advance_cursor();
					held = 1'b1;
				end else begin
					lex_mode = MODE_IDLE;
				end
			end
			default: lex_mode = MODE_IDLE;
		endcase
		if (!held) begin
			if (c == CH_NUL) begin
				run.push_back(make_tok(KIND_EOF, cur_off, 16'd0, cur_line, cur_col));
				clear_lex();
			end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
				advance_cursor();
			end else if (c == CH_LF) begin
				cur_off  = bump(cur_off);
				cur_line = bump(cur_line);
				cur_col  = 16'd1;
			end else if (c == CH_SLASH) begin
				mark_token_start();
				lex_mode = MODE_SLASH;
				advance_cursor();
			end else if (letter_like(c)) begin
				mark_token_start();
				word_buf[0] = c;
				lex_mode = MODE_WORD;
				advance_cursor();
			end else if (digit_like(c)) begin
				mark_token_start();
				lex_mode = MODE_NUMBER;
				advance_cursor();
			end else begin
				case (c)
					CH_LBRACE: k = KIND_LBRACE;
					CH_RBRACE: k = KIND_RBRACE;
					CH_COLON:  k = KIND_COLON;
					CH_SEMI:   k = KIND_SEMI;
					CH_DOT:    k = KIND_DOT;
					default:   k = KIND_ERROR;
				endcase
				run.push_back(make_tok(k, cur_off, 16'd1, cur_line, cur_col));
				advance_cursor();
			end
		end
		if (run.size() != 0) begin
			run[run.size() - 1].last_of_run = 1'b1;
			foreach (run[i]) tokens_due.push_back(run[i]);
		end
	endfunction

	function automatic string tok_str(input tok_t t);
		return $sformatf("kind %0d off %0d len %0d line %0d col %0d last %0b",
		                 t.token_kind, t.start_offset, t.token_length,
		                 t.start_line, t.start_column, t.last_of_run);
	endfunction

	function automatic void note_mismatch(input string what, input tok_t want, input tok_t seen);
		err_count++;
		if (err_count <= 10)
			$display("%0t mismatch (%s): expected %s, got %s", $realtime, what,
			         tok_str(want), tok_str(seen));
	endfunction

	// Stimulus helpers
	function automatic void push_byte(input logic [7:0] b);
		text_queue.push_back(b);
		pushed++;
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
	endfunction

	function automatic logic [7:0] ident_char(input logic any);
		return 8'(ident_chars[$urandom_range(any ? 62 : 52)]);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// One text: mostly well-formed tokens, some noise, terminated by a zero byte.
	function automatic void gen_text();
		int         parts, r, k, len;
		string      w;
		logic [7:0] b;
		parts = $urandom_range(2, 8);
		for (int i = 0; i < parts; i++) begin
			r = $urandom_range(99);
			if (r < 25) begin
				push_str(kw_words[$urandom_range(25)]);
			end else if (r < 35) begin
				w = kw_words[$urandom_range(25)];
				k = $urandom_range(3);
				len = w.len();
				if (k == 1 && len > 1) len--;
				if (k == 0) push_byte(CH_UNDER);
				for (int j = 0; j < len; j++)
					push_byte((k == 2 && j == 0) ? 8'(w[j]) - 8'h20 : 8'(w[j]));
				if (k == 3) push_byte(ident_char(1'b1));
			end else if (r < 45) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
				push_byte(ident_char(1'b0));
				for (int j = 1; j < len; j++) push_byte(ident_char(1'b1));
			end else if (r < 55) begin
				push_byte(8'h30 + 8'($urandom_range(9)));
				repeat ($urandom_range(5))
					push_byte(($urandom_range(3) == 0) ? CH_DOT : 8'h30 + 8'($urandom_range(9)));
			end else if (r < 67) begin
				case ($urandom_range(4))
					0:       push_byte(CH_LBRACE);
					1:       push_byte(CH_RBRACE);
					2:       push_byte(CH_COLON);
					3:       push_byte(CH_SEMI);
					default: push_byte(CH_DOT);
				endcase
			end else if (r < 73) begin
				push_byte(CH_SLASH);
				push_byte(CH_SLASH);
				repeat ($urandom_range(8)) begin
					do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
					push_byte(b);
				end
				// let the end of text close the comment now and then
				if ($urandom_range(4) == 0) break;
				push_byte(CH_LF);
			end else if (r < 77) begin
				push_byte(CH_SLASH);
			end else if (r < 83) begin
				push_byte(8'($urandom_range(1, 255)));
			end else begin
				repeat ($urandom_range(1, 3)) push_byte(blank_char());
			end
			if ($urandom_range(1) != 0) push_byte(blank_char());
		end
		push_byte(CH_NUL);
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (text_queue.size() != 0 || byte_ch.valid || tokens_due.size() != 0)
			@(negedge clk);
	endtask

	// Byte driver: predict on every accepted beat, refill the slot from the queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid     <= 1'b0;
			byte_ch.text_byte <= CH_NUL;
		end else begin
			if (byte_ch.valid && byte_ch.ready) lex_byte(byte_ch.text_byte);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (text_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
					byte_ch.valid     <= 1'b1;
					byte_ch.text_byte <= text_queue.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
		end else begin
			tok_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Token monitor
	always @(posedge clk) begin
		tok_t seen, want;
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			seen.token_kind   = tok_ch.token_kind;
			seen.start_offset = tok_ch.start_offset;
			seen.token_length = tok_ch.token_length;
			seen.start_line   = tok_ch.start_line;
			seen.start_column = tok_ch.start_column;
			seen.last_of_run  = tok_ch.last_of_run;
			if (tokens_due.size() == 0) begin
				note_mismatch("unexpected beat", '0, seen);
			end else begin
				want = tokens_due.pop_front();
				if (seen.token_kind !== want.token_kind || seen.start_offset !== want.start_offset
				    || seen.token_length !== want.token_length
				    || seen.start_line !== want.start_line
				    || seen.start_column !== want.start_column
				    || seen.last_of_run !== want.last_of_run)
					note_mismatch("field", want, seen);
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[keyword_token_lexer] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int mark;
		clear_lex();
		pushed    = 0;
		send_idle = 11;
		recv_idle = 62;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: keyword, punctuation pairs, number with dot, lone slash, comments,
		// blanks, a non-ASCII byte and a comment closed by the end of text.
		push_str("ecu{7.5;}/x//c");
		push_byte(CH_LF);
		push_byte(CH_TAB);
		push_byte(CH_DOT);
		push_byte(CH_CR);
		push_byte(CH_COLON);
		push_byte(8'hFF);
		push_str("//z");
		push_byte(CH_NUL);

		// Every keyword once
		foreach (kw_words[i]) begin
			push_str(kw_words[i]);
			push_byte(blank_char());
		end
		push_byte(CH_NUL);

		mark = pushed;
		while (pushed - mark < PHASE_BYTES) gen_text();
		wait_drained();

		send_idle = 62;
		recv_idle = 11;
		mark = pushed;
		while (pushed - mark < PHASE_BYTES) gen_text();
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		mark = pushed;
		while (pushed - mark < PHASE_BYTES) gen_text();

		// Short texts back to back, each ending in a two-beat byte.
		push_byte(CH_SEMI);
		push_byte(CH_DOT);
		push_str("id 7");
		push_byte(CH_NUL);
		push_str("ecu");
		push_byte(CH_NUL);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tokens_due.size() != 0) err_count++;
		if (err_count == 0) begin
			$display("[keyword_token_lexer] OK");
		end else begin
			$display("[keyword_token_lexer] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/kwl_pkg.sv
rtl/kwl_if.sv
rtl/kwl_scan.sv
rtl/kwl_obuf.sv
rtl/keyword_token_lexer.sv
tb/tb_keyword_token_lexer.sv
